@@ hw/rtl/rotary_combination_lock_assert.svh @@
// assertion macros for the rotary combination lock
// used by the rtl files that carry concurrent checks, no other dependencies
`ifndef ROTARY_COMBINATION_LOCK_ASSERT_SVH
`define ROTARY_COMBINATION_LOCK_ASSERT_SVH

// combinational property checked at every rising clock edge outside reset
`define RCL_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define RCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rcl_pkg.sv @@
// shared types and constants of the rotary combination lock
// no dependencies
package rcl_pkg;

    // fixed field widths
    localparam int SCALE_W    = 7;
    localparam int DIGIT_W    = 6;
    localparam int LAND_W     = 4;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // number of combination phases
    localparam int CODE_LENGTH = 3;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd16;
    localparam logic [DIGIT_W-1:0] DIGIT0_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT1_RESET = 6'd5;
    localparam logic [DIGIT_W-1:0] DIGIT2_RESET = 6'd8;
    localparam logic [LAND_W-1:0]  LAND0_RESET  = 4'd4;
    localparam logic [LAND_W-1:0]  LAND1_RESET  = 4'd3;
    localparam logic [LAND_W-1:0]  LAND2_RESET  = 4'd2;
    localparam logic               FIRST_DIR_RESET = 1'b0;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_COUNT     = 3'd0,
        REG_CODE_DIGIT_0    = 3'd1,
        REG_CODE_DIGIT_1    = 3'd2,
        REG_CODE_DIGIT_2    = 3'd3,
        REG_LANDINGS_0      = 3'd4,
        REG_LANDINGS_1      = 3'd5,
        REG_LANDINGS_2      = 3'd6,
        REG_FIRST_DIRECTION = 3'd7
    } t_cfg_idx;

    // configuration as seen by the step logic
    typedef struct packed {
        logic [SCALE_W-1:0]              scale_count;
        logic [CODE_LENGTH-1:0][DIGIT_W-1:0] code_digit;
        logic [CODE_LENGTH-1:0][LAND_W-1:0]  landings;
        logic                            first_direction;
    } t_cfg;

    // input stage to step logic
    typedef struct packed {
        logic valid;
        logic step_direction;
    } t_stage;

endpackage

@@ hw/rtl/rcl_step_if.sv @@
// input channel of the lock: one detent step per beat
// depends on nothing
interface rcl_step_if;
    logic valid;
    logic ready;
    logic step_direction;

    modport source (output valid, output step_direction, input ready);
    modport sink   (input valid, input step_direction, output ready);
endinterface

@@ hw/rtl/rcl_res_if.sv @@
// result channel of the lock: dial and phase status per beat
// depends on nothing
interface rcl_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] dial_position;
    logic [1:0] phase_index;
    logic       fail_flag;
    logic       step_flag;
    logic       success_flag;
    logic       opened;

    modport source (output valid, output dial_position, output phase_index,
                    output fail_flag, output step_flag, output success_flag,
                    output opened, input ready);
    modport sink   (input valid, input dial_position, input phase_index,
                    input fail_flag, input step_flag, input success_flag,
                    input opened, output ready);
endinterface

@@ hw/rtl/rotary_combination_lock.sv @@
// rotary combination lock: an accepted step beat passes the input register, then the result register
// throughput one step per cycle while results are taken; dial, phase and landing state update in one registered loop
// a stalled result holds the result register; one more beat still enters an empty input register
// reset is synchronous, active low: dial, phase, count and opened flag clear, registers
// return to their defaults, no clearing pass
module rotary_combination_lock #(
    parameter int MAX_POSITIONS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rcl_step_if.sink                       i_step,
    rcl_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [rcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcl_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    rcl_pkg::t_cfg   cfg;
    rcl_pkg::t_stage stage;
    logic            adv;

    // configuration registers
    rcl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // input register
    rcl_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (i_step),
        .i_adv   (adv),
        .o_stage (stage)
    );

    // step logic and result register
    rcl_core #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_stage (stage),
        .o_adv   (adv),
        .o_res   (o_res)
    );

endmodule

@@ hw/rtl/rcl_cfg.sv @@
// configuration register file of the lock
// depends on rcl_pkg
module rcl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output rcl_pkg::t_cfg                  o_cfg
);

    rcl_pkg::t_cfg r_cfg;

    // register writes, one index per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_count     <= rcl_pkg::SCALE_RESET;
            r_cfg.code_digit[0]   <= rcl_pkg::DIGIT0_RESET;
            r_cfg.code_digit[1]   <= rcl_pkg::DIGIT1_RESET;
            r_cfg.code_digit[2]   <= rcl_pkg::DIGIT2_RESET;
            r_cfg.landings[0]     <= rcl_pkg::LAND0_RESET;
            r_cfg.landings[1]     <= rcl_pkg::LAND1_RESET;
            r_cfg.landings[2]     <= rcl_pkg::LAND2_RESET;
            r_cfg.first_direction <= rcl_pkg::FIRST_DIR_RESET;
        end else if (i_cfg_we) begin
            unique case (rcl_pkg::t_cfg_idx'(i_cfg_index))
                rcl_pkg::REG_SCALE_COUNT: begin
                    r_cfg.scale_count <= i_cfg_wdata[rcl_pkg::SCALE_W-1:0];
                end
                rcl_pkg::REG_CODE_DIGIT_0: begin
                    r_cfg.code_digit[0] <= i_cfg_wdata[rcl_pkg::DIGIT_W-1:0];
                end
                rcl_pkg::REG_CODE_DIGIT_1: begin
                    r_cfg.code_digit[1] <= i_cfg_wdata[rcl_pkg::DIGIT_W-1:0];
                end
                rcl_pkg::REG_CODE_DIGIT_2: begin
                    r_cfg.code_digit[2] <= i_cfg_wdata[rcl_pkg::DIGIT_W-1:0];
                end
                rcl_pkg::REG_LANDINGS_0: begin
                    r_cfg.landings[0] <= i_cfg_wdata[rcl_pkg::LAND_W-1:0];
                end
                rcl_pkg::REG_LANDINGS_1: begin
                    r_cfg.landings[1] <= i_cfg_wdata[rcl_pkg::LAND_W-1:0];
                end
                rcl_pkg::REG_LANDINGS_2: begin
                    r_cfg.landings[2] <= i_cfg_wdata[rcl_pkg::LAND_W-1:0];
                end
                rcl_pkg::REG_FIRST_DIRECTION: begin
                    r_cfg.first_direction <= i_cfg_wdata[0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/rcl_in_stage.sv @@
// input register of the lock, one step beat deep
// depends on rcl_pkg and rcl_step_if
module rcl_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rcl_step_if.sink       i_step,
    input  logic           i_adv,
    output rcl_pkg::t_stage o_stage
);

    logic r_valid;
    logic r_dir;

    // take a new beat when empty or when the held one moves on
    assign i_step.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step.ready) begin
            r_valid <= i_step.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_step.valid && i_step.ready) begin
            r_dir <= i_step.step_direction;
        end
    end

    assign o_stage.valid          = r_valid;
    assign o_stage.step_direction = r_dir;

endmodule

@@ hw/rtl/rcl_core.sv @@
// step logic of the lock: dial state, phase tracking and result register
// depends on rcl_pkg, rcl_res_if and rotary_combination_lock_assert.svh
`include "rotary_combination_lock_assert.svh"

module rcl_core #(
    parameter int MAX_POSITIONS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rcl_pkg::t_cfg   i_cfg,
    input  rcl_pkg::t_stage i_stage,
    output logic            o_adv,
    rcl_res_if.source       o_res
);

    localparam int PW = $clog2(MAX_POSITIONS);
    localparam int CW = (PW + 1 > rcl_pkg::SCALE_W) ? PW + 1 : rcl_pkg::SCALE_W;
    localparam int DW = (PW > rcl_pkg::DIGIT_W) ? PW : rcl_pkg::DIGIT_W;
    localparam int PH = rcl_pkg::PHASE_W;
    localparam int LW = rcl_pkg::LAND_W;

    // lock state
    logic [PW-1:0] r_pos;
    logic [PH-1:0] r_phase;
    logic [LW-1:0] r_cnt;
    logic          r_exp;
    logic          r_open;

    // result register
    logic          r_out_valid;
    logic [5:0]    r_out_dial;
    logic [PH-1:0] r_out_phase;
    logic          r_out_fail;
    logic          r_out_step;
    logic          r_out_success;

    logic [PW-1:0] n_pos;
    logic [PH-1:0] n_phase;
    logic [LW-1:0] n_cnt;
    logic          n_exp;
    logic          n_open;
    logic          n_fail;
    logic          n_step;
    logic          n_success;

    logic [CW-1:0] scale_ext;
    logic [CW-1:0] eff_scale;
    logic [CW-1:0] eff_m1;
    logic [CW-1:0] pos_inc;
    logic [DW-1:0] pos_dw;
    logic [PH-1:0] ph_cur;
    logic [PH:0]   ph_inc;
    logic [rcl_pkg::DIGIT_W-1:0] sel_digit;
    logic [LW-1:0] sel_land;
    logic [LW-1:0] cnt_inc;
    logic          dir;
    logic          fire;

    // the result register frees up when empty or taken
    assign o_adv = !r_out_valid || o_res.ready;
    assign fire  = o_adv && i_stage.valid;
    assign dir   = i_stage.step_direction;

    // effective scale, clamped to the dial size and at least one
    always_comb begin
        scale_ext = CW'(i_cfg.scale_count);
        priority if (scale_ext > CW'(MAX_POSITIONS)) begin
            eff_scale = CW'(MAX_POSITIONS);
        end else if (scale_ext == '0) begin
            eff_scale = CW'(1);
        end else begin
            eff_scale = scale_ext;
        end
        eff_m1  = eff_scale - CW'(1);
        pos_inc = CW'(r_pos) + CW'(1);
    end

    // one detent step
    always_comb begin
        n_fail    = (dir != r_exp);
        n_exp     = n_fail ? i_cfg.first_direction : r_exp;
        n_phase   = n_fail ? '0 : r_phase;
        n_step    = 1'b0;
        n_success = 1'b0;
        n_open    = r_open;
        n_cnt     = r_cnt;

        // move the dial with wrap
        if (dir) begin
            n_pos = (pos_inc >= eff_scale) ? '0 : pos_inc[PW-1:0];
        end else begin
            n_pos = (r_pos == '0) ? eff_m1[PW-1:0] : r_pos - PW'(1);
        end
        pos_dw = DW'(n_pos);

        // digit and landings of the awaited phase
        ph_cur = (n_phase < PH'(rcl_pkg::CODE_LENGTH)) ? n_phase : '0;
        ph_inc = {1'b0, ph_cur} + (PH + 1)'(1);
        unique case (ph_cur)
            2'd1: begin
                sel_digit = i_cfg.code_digit[1];
                sel_land  = i_cfg.landings[1];
            end
            2'd2: begin
                sel_digit = i_cfg.code_digit[2];
                sel_land  = i_cfg.landings[2];
            end
            default: begin
                sel_digit = i_cfg.code_digit[0];
                sel_land  = i_cfg.landings[0];
            end
        endcase
        cnt_inc = r_cnt + LW'(1);

        // landing on the digit, phase completes at the required count
        if (pos_dw == DW'(sel_digit)) begin
            n_cnt = cnt_inc;
            if (cnt_inc == sel_land) begin
                n_step = 1'b1;
                n_cnt  = '0;
                n_exp  = !dir;
                if (ph_inc >= (PH + 1)'(rcl_pkg::CODE_LENGTH)) begin
                    n_success = 1'b1;
                    n_open    = 1'b1;
                    n_phase   = '0;
                end else begin
                    n_phase = ph_inc[PH-1:0];
                end
            end
        end
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= '0;
            r_cnt       <= '0;
            r_exp       <= rcl_pkg::FIRST_DIR_RESET;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_exp   <= n_exp;
                r_open  <= n_open;
            end
            if (o_adv) begin
                r_out_valid <= i_stage.valid;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_dial    <= pos_dw[5:0];
            r_out_phase   <= n_phase;
            r_out_fail    <= n_fail;
            r_out_step    <= n_step;
            r_out_success <= n_success;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.dial_position = r_out_dial;
    assign o_res.phase_index   = r_out_phase;
    assign o_res.fail_flag     = r_out_fail;
    assign o_res.step_flag     = r_out_step;
    assign o_res.success_flag  = r_out_success;
    assign o_res.opened        = r_open;

    // checks
    `RCL_ASSERT(a_phase_range, i_clk, i_rst_n, r_phase < PH'(rcl_pkg::CODE_LENGTH), "phase out of range")
    `RCL_ASSERT_IMPL(a_success_step, i_clk, i_rst_n, r_out_valid && r_out_success, r_out_step && r_open && (r_out_phase == '0), "success without phase completion")
    `RCL_ASSERT_IMPL(a_step_clears, i_clk, i_rst_n, r_out_valid && r_out_step, r_cnt == '0, "landing count not cleared on phase step")
    `RCL_ASSERT_NEXT(a_open_sticky, i_clk, i_rst_n, r_open, r_open, "opened flag dropped")

endmodule

@@ sim/rotary_combination_lock_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the rotary combination lock: directed and random detent steps
// depends on rcl_pkg, rcl_step_if, rcl_res_if and rotary_combination_lock
module rotary_combination_lock_tb;

    localparam int          DIAL_MAX     = 64;
    localparam int          GAP_PCT      = 71;
    localparam int          BOTH_PCT     = 17;
    localparam int          PROPER_PCT   = 90;
    localparam int          PHASE_COUNT  = 12;
    localparam int          PHASE_ITEMS  = 150;
    localparam int unsigned TIMEOUT_NS   = 2000000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // one result beat as the lock should report it
    typedef struct packed {
        logic [5:0] dial_position;
        logic [1:0] phase_index;
        logic       misturn;
        logic       phase_done;
        logic       unlocked;
        logic       opened;
    } t_dial_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    rcl_pkg::t_cfg_idx              cfg_index;
    logic [rcl_pkg::CFG_DATA_W-1:0] cfg_wdata;

    rcl_step_if step_bus ();
    rcl_res_if  res_bus ();

    rotary_combination_lock #(
        .MAX_POSITIONS(DIAL_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    // register shadow
    logic [rcl_pkg::SCALE_W-1:0] cfg_scale;
    logic [rcl_pkg::DIGIT_W-1:0] cfg_digit [rcl_pkg::CODE_LENGTH];
    logic [rcl_pkg::LAND_W-1:0]  cfg_land [rcl_pkg::CODE_LENGTH];
    logic                        cfg_first_dir;

    // lock state as predicted
    logic [rcl_pkg::DIGIT_W-1:0] dial_pos;
    logic [rcl_pkg::PHASE_W-1:0] lock_phase;
    logic [rcl_pkg::LAND_W-1:0]  land_count;
    logic                        want_dir;
    logic                        is_open;

    t_dial_result dial_results_due[$];
    int unsigned  sender_gap_pct;
    int unsigned  receiver_stall_pct;
    int unsigned  mismatch_count;
    int unsigned  result_seq;

    always #1 i_clk = ~i_clk;

    // one detent step through the lock, updates the predicted state
    function automatic t_dial_result turn_dial(input logic dir);
        t_dial_result r;
        int unsigned  span;
        int unsigned  slot;
        r    = '0;
        span = (cfg_scale > DIAL_MAX) ? DIAL_MAX : cfg_scale;
        if (span == 0) begin
            span = 1;
        end
        // wrong turn restarts the sequence, landings are kept
        if (dir != want_dir) begin
            want_dir   = cfg_first_dir;
            lock_phase = '0;
            r.misturn  = 1'b1;
        end
        if (dir) begin
            dial_pos = (dial_pos + 1 >= span) ? '0 : dial_pos + 6'd1;
        end else begin
            dial_pos = (dial_pos == 0) ? 6'(span - 1) : dial_pos - 6'd1;
        end
        slot = (lock_phase < rcl_pkg::CODE_LENGTH) ? lock_phase : 0;
        if (dial_pos == cfg_digit[slot]) begin
            land_count = land_count + 4'd1;
            if (land_count == cfg_land[slot]) begin
                r.phase_done = 1'b1;
                land_count   = '0;
                slot         = slot + 1;
                if (slot >= rcl_pkg::CODE_LENGTH) begin
                    r.unlocked = 1'b1;
                    slot       = 0;
                    is_open    = 1'b1;
                end
                lock_phase = 2'(slot);
                want_dir   = ~dir;
            end
        end
        r.dial_position = dial_pos;
        r.phase_index   = lock_phase;
        r.opened        = is_open;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string label, input int got, input int want_v);
        if (got != want_v) begin
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      result_seq, label, got, want_v));
        end
    endtask

    // result side: compare each accepted beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_dial_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (dial_results_due.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = dial_results_due.pop_front();
                check_field("dial", res_bus.dial_position, want.dial_position);
                check_field("phase", res_bus.phase_index, want.phase_index);
                check_field("misturn", res_bus.fail_flag, want.misturn);
                check_field("phase done", res_bus.step_flag, want.phase_done);
                check_field("unlocked", res_bus.success_flag, want.unlocked);
                check_field("opened", res_bus.opened, want.opened);
                result_seq++;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                sender_gap_pct     = GAP_PCT;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_gap_pct     = 0;
                receiver_stall_pct = GAP_PCT;
            end
            IDLE_BOTH: begin
                sender_gap_pct     = BOTH_PCT;
                receiver_stall_pct = BOTH_PCT;
            end
            default: begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
        endcase
    endtask

    // one step beat, with a random gap ahead of it
    task automatic send_step(input logic dir);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            @(negedge i_clk);
            step_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        step_bus.valid          <= 1'b1;
        step_bus.step_direction <= dir;
        @(posedge i_clk);
        while (!step_bus.ready) begin
            @(posedge i_clk);
        end
        dial_results_due.push_back(turn_dial(dir));
    endtask

    // drop valid and wait until every result is back
    task automatic settle_idle();
        @(negedge i_clk);
        step_bus.valid <= 1'b0;
        while (dial_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input rcl_pkg::t_cfg_idx idx,
                             input logic [rcl_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            rcl_pkg::REG_SCALE_COUNT:     cfg_scale     = val;
            rcl_pkg::REG_CODE_DIGIT_0:    cfg_digit[0]  = val[rcl_pkg::DIGIT_W-1:0];
            rcl_pkg::REG_CODE_DIGIT_1:    cfg_digit[1]  = val[rcl_pkg::DIGIT_W-1:0];
            rcl_pkg::REG_CODE_DIGIT_2:    cfg_digit[2]  = val[rcl_pkg::DIGIT_W-1:0];
            rcl_pkg::REG_LANDINGS_0:      cfg_land[0]   = val[rcl_pkg::LAND_W-1:0];
            rcl_pkg::REG_LANDINGS_1:      cfg_land[1]   = val[rcl_pkg::LAND_W-1:0];
            rcl_pkg::REG_LANDINGS_2:      cfg_land[2]   = val[rcl_pkg::LAND_W-1:0];
            rcl_pkg::REG_FIRST_DIRECTION: cfg_first_dir = val[0];
            default: ;
        endcase
    endtask

    // mostly the turn the lock wants, sometimes a random one
    function automatic logic pick_direction();
        if ($urandom_range(0, 99) < PROPER_PCT) begin
            return want_dir;
        end
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [rcl_pkg::CFG_DATA_W-1:0] pick_digit(input int unsigned span);
        if ($urandom_range(0, 3) != 0) begin
            return 7'($urandom_range(0, span - 1));
        end
        return 7'($urandom_range(0, 63));
    endfunction

    function automatic logic [rcl_pkg::CFG_DATA_W-1:0] pick_landings();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return 7'($urandom_range(1, 3));
        end else if (sel < 9) begin
            return 7'($urandom_range(4, 15));
        end
        return '0;
    endfunction

    // small dials most of the time so that landings come often
    task automatic randomize_settings();
        int unsigned                    sel;
        int unsigned                    span;
        logic [rcl_pkg::CFG_DATA_W-1:0] scale_v;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            scale_v = 7'($urandom_range(1, 6));
        end else if (sel == 6) begin
            scale_v = 7'($urandom_range(7, 64));
        end else if (sel == 7) begin
            scale_v = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd2;
        end else if (sel == 8) begin
            scale_v = 7'($urandom_range(65, 127));
        end else begin
            scale_v = ($urandom_range(0, 1) != 0) ? 7'd0 : 7'd127;
        end
        span = (scale_v > DIAL_MAX) ? DIAL_MAX : ((scale_v == 0) ? 1 : scale_v);
        write_reg(rcl_pkg::REG_SCALE_COUNT, scale_v);
        write_reg(rcl_pkg::REG_CODE_DIGIT_0, pick_digit(span));
        write_reg(rcl_pkg::REG_CODE_DIGIT_1, pick_digit(span));
        write_reg(rcl_pkg::REG_CODE_DIGIT_2, pick_digit(span));
        write_reg(rcl_pkg::REG_LANDINGS_0, pick_landings());
        write_reg(rcl_pkg::REG_LANDINGS_1, pick_landings());
        write_reg(rcl_pkg::REG_LANDINGS_2, pick_landings());
        write_reg(rcl_pkg::REG_FIRST_DIRECTION, 7'($urandom_range(0, 1)));
    endtask

    // default registers: wrap below zero and a wrong turn
    task automatic test_reset_state();
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
    endtask

    // dial left beyond a shrunken scale
    task automatic test_scale_shrink();
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd8);
        send_step(1'b1);
        send_step(1'b0);
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd4);
        send_step(1'b0);
        send_step(1'b1);
    endtask

    // full combination on a tiny dial, then the sticky flag and a late first direction
    task automatic test_short_unlock();
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd4);
        write_reg(rcl_pkg::REG_CODE_DIGIT_0, 7'd3);
        write_reg(rcl_pkg::REG_CODE_DIGIT_1, 7'd1);
        write_reg(rcl_pkg::REG_CODE_DIGIT_2, 7'd2);
        write_reg(rcl_pkg::REG_LANDINGS_0, 7'd1);
        write_reg(rcl_pkg::REG_LANDINGS_1, 7'd1);
        write_reg(rcl_pkg::REG_LANDINGS_2, 7'd1);
        for (int n = 0; n < 12 && !is_open; n++) begin
            send_step(want_dir);
        end
        settle_idle();
        write_reg(rcl_pkg::REG_FIRST_DIRECTION, 7'd1);
        send_step(1'b0);
        send_step(1'b1);
    endtask

    // scale of zero, above the maximum, at the maximum, and an unreachable digit
    task automatic test_scale_extremes();
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd0);
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b1);
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd127);
        send_step(1'b0);
        send_step(1'b1);
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd64);
        send_step(1'b0);
        settle_idle();
        write_reg(rcl_pkg::REG_CODE_DIGIT_0, 7'd63);
        write_reg(rcl_pkg::REG_LANDINGS_0, 7'd15);
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd8);
        send_step(1'b1);
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd2);
        send_step(1'b1);
        send_step(1'b1);
    endtask

    // single-position dial lands every step: zero landings need the counter to wrap
    task automatic test_landing_wrap();
        settle_idle();
        write_reg(rcl_pkg::REG_SCALE_COUNT, 7'd1);
        write_reg(rcl_pkg::REG_CODE_DIGIT_0, 7'd0);
        write_reg(rcl_pkg::REG_LANDINGS_0, 7'd0);
        send_step(~want_dir);
        repeat (16) send_step(want_dir);
    endtask

    // random settings, mostly well-formed turning, every idle pattern
    task automatic test_random_phases();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle_idle();
            randomize_settings();
            set_idle(t_idle_mode'(ph % 4));
            repeat (PHASE_ITEMS) send_step(pick_direction());
        end
    endtask

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = rcl_pkg::REG_SCALE_COUNT;
        cfg_wdata               = '0;
        step_bus.valid          = 1'b0;
        step_bus.step_direction = 1'b0;
        res_bus.ready           = 1'b0;
        mismatch_count          = 0;
        result_seq              = 0;
        cfg_scale               = rcl_pkg::SCALE_RESET;
        cfg_digit[0]            = rcl_pkg::DIGIT0_RESET;
        cfg_digit[1]            = rcl_pkg::DIGIT1_RESET;
        cfg_digit[2]            = rcl_pkg::DIGIT2_RESET;
        cfg_land[0]             = rcl_pkg::LAND0_RESET;
        cfg_land[1]             = rcl_pkg::LAND1_RESET;
        cfg_land[2]             = rcl_pkg::LAND2_RESET;
        cfg_first_dir           = rcl_pkg::FIRST_DIR_RESET;
        dial_pos                = '0;
        lock_phase              = '0;
        land_count              = '0;
        want_dir                = rcl_pkg::FIRST_DIR_RESET;
        is_open                 = 1'b0;
        set_idle(IDLE_NONE);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_scale_shrink();
        test_short_unlock();
        set_idle(IDLE_BOTH);
        test_scale_extremes();
        test_landing_wrap();
        test_random_phases();

        settle_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
